// ----- hw/rtl/psbpu_pkg.sv -----
// Shared types, constants and helper functions for the seven-bit pixel unpacker.
`default_nettype none

package psbpu_pkg;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_IMAGE_WIDTH  = 3'd0;
    localparam cfg_index_t REG_IMAGE_HEIGHT = 3'd1;
    localparam cfg_index_t REG_CROP_COL_MIN = 3'd2;
    localparam cfg_index_t REG_CROP_ROW_MIN = 3'd3;
    localparam cfg_index_t REG_CROP_COL_MAX = 3'd4;
    localparam cfg_index_t REG_CROP_ROW_MAX = 3'd5;

    // Whole-screen geometry.
    localparam logic [7:0] SCREEN_COLS = 8'd140;
    localparam logic [7:0] SCREEN_ROWS = 8'd192;

    localparam int ADDR_W   = 14;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 48;

    typedef logic [ADDR_W-1:0] addr_t;

    // One result item, last field in the lowest bits.
    typedef struct packed {
        logic       image_done;
        addr_t      next_address;
        logic [7:0] pixel_column;
        logic [7:0] pixel_row;
        logic       second_valid;
        logic [3:0] pixel_second;
        logic       first_valid;
        logic [3:0] pixel_first;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    // Bit i of the source moves to bit 6-i.
    function automatic logic [6:0] rev7(input logic [6:0] v);
        logic [6:0] r;
        for (int i = 0; i < 7; i++) begin
            r[6-i] = v[i];
        end
        return r;
    endfunction

    // Interleaved screen address: (r/64)*0x28 + ((r%64)/8)*0x80 + (r%8)*0x400
    // plus the bank select from the low byte bit and the byte pair offset.
    function automatic addr_t screen_address(input logic [7:0] row, input logic [6:0] byte_idx);
        logic [ADDR_W-1:0] group_part;
        logic [ADDR_W-1:0] block_part;
        logic [ADDR_W-1:0] line_part;
        logic [ADDR_W-1:0] bank_part;
        logic [ADDR_W-1:0] pair_part;
        group_part = (ADDR_W'(row[7:6]) << 5) + (ADDR_W'(row[7:6]) << 3);
        block_part = ADDR_W'(row[5:3]) << 7;
        line_part  = ADDR_W'(row[2:0]) << 10;
        bank_part  = ADDR_W'(byte_idx[0]) << 13;
        pair_part  = ADDR_W'(byte_idx[6:1]);
        return group_part + block_part + line_part + bank_part + pair_part;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/packed_seven_bit_pixel_unpacker.sv -----
// Top level of the seven-bit packed pixel unpacker with its config registers.
`default_nettype none

// Each accepted source byte contributes its low 7 bits, bit-reversed, to a small
// bit store and yields one result item with up to two 4-bit pixels, their row and
// column, crop-window valid flags, the address of the byte expected next and an
// image-complete flag. The unpacker takes one byte per clock; its result goes into
// a single output register on acceptance, and a new byte is taken whenever that
// register is empty or being drained in the same cycle. Image width 0 selects the
// whole 140x192 screen with interleaved row bases and alternating 8K banks; any
// other width uses the width and height registers with sequential addresses from
// 0. Bytes arriving after the last row produce items with no valid pixels. The
// user must configure via the cfg channel only while idle; it is not enforced.
module packed_seven_bit_pixel_unpacker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Configuration write channel.
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [psbpu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                        cfg_data,
    // Source bytes.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [psbpu_pkg::TDATA_IN_W-1:0]  s_tdata,   // [7:0] source_byte
    // Result items.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [3:0] pixel_first, [4] first_valid, [8:5] pixel_second, [9] second_valid,
    // [17:10] pixel_row, [25:18] pixel_column, [39:26] next_address,
    // [40] image_done, [47:41] zero
    output logic [psbpu_pkg::TDATA_OUT_W-1:0]      m_tdata
);
    import psbpu_pkg::*;

    // Configuration registers.
    logic [7:0] image_width_reg;
    logic [7:0] image_height_reg;
    logic [7:0] crop_col_min_reg;
    logic [7:0] crop_row_min_reg;
    logic [7:0] crop_col_max_reg;
    logic [7:0] crop_row_max_reg;

    // Unpack state.
    logic [6:0] bit_store_reg,   bit_store_next;
    logic [2:0] bits_left_reg,   bits_left_next;
    logic [7:0] column_count_reg, column_count_next;
    logic [7:0] row_count_reg,   row_count_next;
    logic [6:0] byte_in_row_reg, byte_in_row_next;
    addr_t      seq_addr_reg,    seq_addr_next;
    logic       done_flag_reg,   done_flag_next;

    // Output stage.
    logic    m_tvalid_reg;
    result_t result_reg, result_next;

    logic s_accept;
    logic m_accept;
    logic cfg_accept;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign s_tready   = !m_tvalid_reg || m_tready;
    assign s_accept   = s_tvalid && s_tready;
    assign m_accept   = m_tvalid_reg && m_tready;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {(TDATA_OUT_W - RESULT_W)'(0), result_reg};

    // ------------------------------------------------------------------
    // Configuration decode.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= 8'd0;
            image_height_reg <= 8'd0;
            crop_col_min_reg <= 8'd0;
            crop_row_min_reg <= 8'd0;
            crop_col_max_reg <= 8'hff;
            crop_row_max_reg <= 8'hff;
        end else if (cfg_accept) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                REG_CROP_COL_MIN: crop_col_min_reg <= cfg_data;
                REG_CROP_ROW_MIN: crop_row_min_reg <= cfg_data;
                REG_CROP_COL_MAX: crop_col_max_reg <= cfg_data;
                REG_CROP_ROW_MAX: crop_row_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Per-byte unpack logic.
    logic       screen_mode;
    logic [7:0] row_width;
    logic [7:0] row_total;
    logic       complete_now;
    logic       complete_after;
    logic [6:0] rev_bits;
    logic [1:0] b_cnt;
    logic [2:0] nb;
    logic [8:0] ncol;
    logic [8:0] ncol_plus;
    logic       has_second;
    logic       row_end;
    logic [7:0] row_inc;
    logic       row_in_crop;
    logic       col_in_crop;
    logic       ncol_in_crop;
    logic [10:0] merged;
    logic [3:0] p1;
    logic [3:0] p2;

    assign screen_mode = (image_width_reg == 8'd0);
    assign row_width   = screen_mode ? SCREEN_COLS : image_width_reg;
    assign row_total   = screen_mode ? SCREEN_ROWS : image_height_reg;
    assign complete_now = done_flag_reg || (row_count_reg >= row_total);

    assign rev_bits  = rev7(s_tdata[6:0]);
    assign b_cnt     = bits_left_reg[1:0];
    assign nb        = {1'b0, b_cnt} + 3'd3;
    assign ncol      = {1'b0, column_count_reg} + 9'd1;
    assign ncol_plus = ncol + 9'd1;

    // Leftover bits shifted up, new bits filling the low end below them.
    assign merged = ({4'd0, bit_store_reg} << (3'd4 - {1'b0, b_cnt}))
                  | {4'd0, rev_bits >> nb};
    assign p1 = merged[3:0];

    // A second pixel exists when the row has room and enough bits remain.
    assign has_second = (ncol < {1'b0, row_width}) && (nb >= 3'd4);
    assign p2 = 4'(rev_bits >> (nb - 3'd4));

    assign row_end = has_second ? (ncol_plus >= {1'b0, row_width})
                                : (ncol >= {1'b0, row_width});
    assign row_inc = (row_count_reg < 8'hff) ? row_count_reg + 8'd1 : row_count_reg;

    assign row_in_crop  = (row_count_reg >= crop_row_min_reg) &&
                          (row_count_reg <= crop_row_max_reg);
    assign col_in_crop  = (column_count_reg >= crop_col_min_reg) &&
                          (column_count_reg <= crop_col_max_reg);
    assign ncol_in_crop = (ncol >= {1'b0, crop_col_min_reg}) &&
                          (ncol <= {1'b0, crop_col_max_reg});

    always_comb begin
        bit_store_next    = bit_store_reg;
        bits_left_next    = bits_left_reg;
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        byte_in_row_next  = byte_in_row_reg;
        seq_addr_next     = seq_addr_reg;
        done_flag_next    = done_flag_reg;

        result_next              = '0;
        result_next.pixel_row    = row_count_reg;
        result_next.pixel_column = column_count_reg;

        if (!complete_now) begin
            result_next.pixel_first = p1;
            result_next.first_valid = row_in_crop && col_in_crop;
            if (has_second) begin
                result_next.pixel_second = p2;
                result_next.second_valid = row_in_crop && ncol_in_crop;
            end

            bit_store_next = rev_bits;
            seq_addr_next  = seq_addr_reg + addr_t'(1);
            if (row_end) begin
                column_count_next = 8'd0;
                bits_left_next    = 3'd0;
                byte_in_row_next  = 7'd0;
                row_count_next    = row_inc;
                if (row_inc >= row_total) begin
                    done_flag_next = 1'b1;
                end
            end else begin
                bits_left_next    = has_second ? nb - 3'd4 : nb;
                byte_in_row_next  = byte_in_row_reg + 7'd1;
                column_count_next = has_second ? ncol_plus[7:0] : ncol[7:0];
            end
        end

        // Address and completion are reported for the state after this byte.
        complete_after = done_flag_next || (row_count_next >= row_total);
        result_next.image_done = complete_after;
        if (!screen_mode) begin
            result_next.next_address = seq_addr_next;
        end else if (complete_after) begin
            result_next.next_address = '0;
        end else begin
            result_next.next_address = screen_address(row_count_next, byte_in_row_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_store_reg    <= '0;
            bits_left_reg    <= '0;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            byte_in_row_reg  <= '0;
            seq_addr_reg     <= '0;
            done_flag_reg    <= 1'b0;
        end else if (s_accept) begin
            bit_store_reg    <= bit_store_next;
            bits_left_reg    <= bits_left_next;
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            byte_in_row_reg  <= byte_in_row_next;
            seq_addr_reg     <= seq_addr_next;
            done_flag_reg    <= done_flag_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_accept) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            result_reg <= result_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        done_flag_reg |=> done_flag_reg)
        else $error("done flag cleared without reset");

    a_bits_left_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !bits_left_reg[2])
        else $error("bit store holds more than three leftover bits");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid_reg |-> s_tready)
        else $error("input stalled while output register is empty");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid_reg)
        else $error("accepted item produced no result");

    a_second_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && result_next.second_valid) |-> (b_cnt != 2'd0))
        else $error("second pixel reported without enough stored bits");

endmodule

`default_nettype wire

// ----- sim/tb_packed_seven_bit_pixel_unpacker.sv -----
// Self-checking testbench for the seven-bit packed pixel unpacker.
`default_nettype none

module tb_packed_seven_bit_pixel_unpacker;
    import psbpu_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int ROW_CAP      = 250;
    localparam int HOLD_CYCLES  = 300;
    localparam int REPORT_LIMIT = 40;

    typedef enum logic [1:0] {
        PLAN_WRITE,
        PLAN_BYTE,
        PLAN_BYTE_KNOWN
    } plan_kind_t;

    typedef struct packed {
        plan_kind_t kind;
        cfg_index_t index;
        logic [7:0] value;
        result_t    known;
    } plan_row_t;

    // Known results are written {image_done, next_address, pixel_column, pixel_row,
    // second_valid, pixel_second, first_valid, pixel_first}.
    localparam plan_row_t DIRECTED_PLAN [0:31] = '{
        '{PLAN_BYTE_KNOWN, '0, 8'h00,
          {1'b0, 14'h2000, 8'd0, 8'd0, 1'b0, 4'h0, 1'b1, 4'h0}},
        '{PLAN_BYTE_KNOWN, '0, 8'hFF,
          {1'b0, 14'd1, 8'd1, 8'd0, 1'b1, 4'hF, 1'b1, 4'h1}},
        '{PLAN_BYTE,  '0, 8'h80, '0},
        '{PLAN_BYTE,  '0, 8'h55, '0},
        '{PLAN_BYTE,  '0, 8'h2A, '0},
        '{PLAN_BYTE,  '0, 8'h7F, '0},
        // Section mode with zero height: the image is complete at once.
        '{PLAN_WRITE, REG_IMAGE_WIDTH,  8'd1, '0},
        '{PLAN_WRITE, REG_IMAGE_HEIGHT, 8'd0, '0},
        '{PLAN_BYTE_KNOWN, '0, 8'h3C,
          {1'b1, 14'd6, 8'd10, 8'd0, 1'b0, 4'h0, 1'b0, 4'h0}},
        // The column counter is now past the width, so the next byte ends the row.
        '{PLAN_WRITE, REG_IMAGE_HEIGHT, 8'd255, '0},
        '{PLAN_WRITE, REG_CROP_COL_MAX, 8'd0,   '0},
        '{PLAN_WRITE, REG_CROP_ROW_MIN, 8'd1,   '0},
        '{PLAN_BYTE,  '0, 8'h01, '0},
        '{PLAN_BYTE,  '0, 8'h40, '0},
        '{PLAN_BYTE,  '0, 8'h7E, '0},
        '{PLAN_WRITE, REG_IMAGE_WIDTH,  8'd7,   '0},
        '{PLAN_WRITE, REG_CROP_COL_MIN, 8'd2,   '0},
        '{PLAN_WRITE, REG_CROP_COL_MAX, 8'd5,   '0},
        '{PLAN_WRITE, REG_CROP_ROW_MAX, 8'd200, '0},
        '{PLAN_BYTE,  '0, 8'h12, '0},
        '{PLAN_BYTE,  '0, 8'h34, '0},
        '{PLAN_BYTE,  '0, 8'h56, '0},
        '{PLAN_BYTE,  '0, 8'h78, '0},
        '{PLAN_BYTE,  '0, 8'h9A, '0},
        '{PLAN_WRITE, REG_IMAGE_WIDTH,  8'd0,   '0},
        '{PLAN_WRITE, REG_CROP_COL_MIN, 8'd0,   '0},
        '{PLAN_WRITE, REG_CROP_ROW_MIN, 8'd0,   '0},
        '{PLAN_WRITE, REG_CROP_COL_MAX, 8'd255, '0},
        '{PLAN_WRITE, REG_CROP_ROW_MAX, 8'd255, '0},
        '{PLAN_BYTE,  '0, 8'hF0, '0},
        '{PLAN_BYTE,  '0, 8'h0F, '0},
        '{PLAN_BYTE,  '0, 8'hAA, '0}
    };

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    cfg_index_t             cfg_index = '0;
    logic [7:0]             cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata   = '0;   // [7:0] source_byte
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // [3:0] pixel_first, [4] first_valid, [8:5] pixel_second, [9] second_valid,
    // [17:10] pixel_row, [25:18] pixel_column, [39:26] next_address, [40] image_done
    logic [TDATA_OUT_W-1:0] m_tdata;

    packed_seven_bit_pixel_unpacker i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Mirror of the configuration and the unpacking state.
    logic [7:0] reg_width   = 8'd0;
    logic [7:0] reg_height  = 8'd0;
    logic [7:0] reg_col_min = 8'd0;
    logic [7:0] reg_row_min = 8'd0;
    logic [7:0] reg_col_max = 8'd255;
    logic [7:0] reg_row_max = 8'd255;
    logic [6:0] store_bits  = '0;
    logic [2:0] store_count = '0;
    logic [7:0] col_cnt     = '0;
    logic [7:0] row_cnt     = '0;
    logic [6:0] byte_idx    = '0;
    addr_t      seq_addr    = '0;
    logic       done_seen   = 1'b0;

    result_t pending_pixels [$];
    int      mismatch_count = 0;
    int      items_checked  = 0;
    int      tx_gap_pct     = 10;
    bit      hold_req       = 1'b0;

    function automatic int rows_in_image();
        return (reg_width == 8'd0) ? int'(SCREEN_ROWS) : int'(reg_height);
    endfunction

    function automatic bit image_complete();
        return done_seen || int'(row_cnt) >= rows_in_image();
    endfunction

    function automatic bit in_window(input int row, input int col);
        return row >= int'(reg_row_min) && row <= int'(reg_row_max) &&
               col >= int'(reg_col_min) && col <= int'(reg_col_max);
    endfunction

    function automatic addr_t fetch_address();
        int r;
        int b;
        int a;
        if (reg_width != 8'd0) begin
            return seq_addr;
        end
        if (image_complete()) begin
            return '0;
        end
        r = int'(row_cnt);
        b = int'(byte_idx);
        a = (r / 64) * 'h28 + ((r % 64) / 8) * 'h80 + (r % 8) * 'h400;
        a = a + (b % 2) * 8192 + b / 2;
        return addr_t'(a);
    endfunction

    task automatic unpack_byte(input logic [7:0] src, output result_t res);
        int         width;
        int         held;
        int         total_bits;
        int         next_col;
        int         flipped;
        logic [6:0] rev;
        res = '0;
        res.pixel_row    = row_cnt;
        res.pixel_column = col_cnt;
        if (!image_complete()) begin
            width = (reg_width == 8'd0) ? int'(SCREEN_COLS) : int'(reg_width);
            held  = int'(store_count) & 3;
            for (int i = 0; i < 7; i++) begin
                rev[6 - i] = src[i];
            end
            flipped    = int'(rev);
            total_bits = held + 3;
            next_col   = int'(col_cnt) + 1;
            res.pixel_first = 4'(((int'(store_bits) << (4 - held)) |
                                  (flipped >> total_bits)) & 15);
            res.first_valid = in_window(int'(row_cnt), int'(col_cnt));
            // A second pixel needs room in the row and four bits left over.
            if (next_col < width && total_bits >= 4) begin
                total_bits       = total_bits - 4;
                res.pixel_second = 4'((flipped >> total_bits) & 15);
                res.second_valid = in_window(int'(row_cnt), next_col);
                next_col++;
            end
            store_bits  = rev;
            store_count = 3'(total_bits);
            byte_idx    = byte_idx + 7'd1;
            seq_addr    = seq_addr + addr_t'(1);
            if (next_col >= width) begin
                col_cnt     = '0;
                store_count = '0;
                byte_idx    = '0;
                if (row_cnt < 8'd255) begin
                    row_cnt = row_cnt + 8'd1;
                end
                if (int'(row_cnt) >= rows_in_image()) begin
                    done_seen = 1'b1;
                end
            end else begin
                col_cnt = 8'(next_col);
            end
        end
        res.next_address = fetch_address();
        res.image_done   = image_complete();
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] crop_bound(input logic [7:0] open_value);
        case ($urandom_range(0, 7))
            0: begin
                return 8'd0;
            end
            1: begin
                return 8'd255;
            end
            2, 3: begin
                return 8'($urandom_range(0, 255));
            end
            default: begin
                return open_value;
            end
        endcase
    endfunction

    task automatic note_mismatch(input string field, input logic [RESULT_W-1:0] got,
                                 input logic [RESULT_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("item %0d: %s is 0x%0h, expected 0x%0h", items_checked, field, got, want);
        end
    endtask

    task automatic check_pixel_item(input logic [TDATA_OUT_W-1:0] word);
        result_t got;
        result_t want;
        got = result_t'(word[RESULT_W-1:0]);
        if (pending_pixels.size() == 0) begin
            note_mismatch("item with nothing expected", word[RESULT_W-1:0], '0);
        end else begin
            want = pending_pixels.pop_front();
            if (word[TDATA_OUT_W-1:RESULT_W] !== '0)
                note_mismatch("padding", RESULT_W'(word[TDATA_OUT_W-1:RESULT_W]), '0);
            if (got.pixel_first !== want.pixel_first)
                note_mismatch("pixel_first", RESULT_W'(got.pixel_first),
                              RESULT_W'(want.pixel_first));
            if (got.first_valid !== want.first_valid)
                note_mismatch("first_valid", RESULT_W'(got.first_valid),
                              RESULT_W'(want.first_valid));
            if (got.pixel_second !== want.pixel_second)
                note_mismatch("pixel_second", RESULT_W'(got.pixel_second),
                              RESULT_W'(want.pixel_second));
            if (got.second_valid !== want.second_valid)
                note_mismatch("second_valid", RESULT_W'(got.second_valid),
                              RESULT_W'(want.second_valid));
            if (got.pixel_row !== want.pixel_row)
                note_mismatch("pixel_row", RESULT_W'(got.pixel_row),
                              RESULT_W'(want.pixel_row));
            if (got.pixel_column !== want.pixel_column)
                note_mismatch("pixel_column", RESULT_W'(got.pixel_column),
                              RESULT_W'(want.pixel_column));
            if (got.next_address !== want.next_address)
                note_mismatch("next_address", RESULT_W'(got.next_address),
                              RESULT_W'(want.next_address));
            if (got.image_done !== want.image_done)
                note_mismatch("image_done", RESULT_W'(got.image_done),
                              RESULT_W'(want.image_done));
        end
        items_checked++;
    endtask

    // Leaves cfg_valid high so that back-to-back writes need no second assignment.
    task automatic set_register(input cfg_index_t idx, input logic [7:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_IMAGE_WIDTH: begin
                reg_width = val;
            end
            REG_IMAGE_HEIGHT: begin
                reg_height = val;
            end
            REG_CROP_COL_MIN: begin
                reg_col_min = val;
            end
            REG_CROP_ROW_MIN: begin
                reg_row_min = val;
            end
            REG_CROP_COL_MAX: begin
                reg_col_max = val;
            end
            REG_CROP_ROW_MAX: begin
                reg_row_max = val;
            end
            default: begin
            end
        endcase
    endtask

    task automatic push_source_byte(input logic [7:0] src, input bit use_known,
                                    input result_t known);
        result_t want;
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat (gap_length()) @(posedge aclk);
        end
        s_tdata   <= src;
        s_tvalid  <= 1'b1;
        cfg_valid <= 1'b0;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        unpack_byte(src, want);
        pending_pixels.push_back(use_known ? known : want);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    initial begin : result_sink
        int stall_left;
        int busy_pct;
        stall_left = 0;
        busy_pct   = 20;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                check_pixel_item(m_tdata);
            end
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && $urandom_range(0, 99) < busy_pct) begin
                stall_left = gap_length();
            end
            if ($urandom_range(0, 99) == 0) begin
                case ($urandom_range(0, 2))
                    0: busy_pct = 0;
                    1: busy_pct = 15;
                    default: busy_pct = 50;
                endcase
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : source_feed
        plan_row_t  row;
        bit         after_byte;
        bit         busy;
        int         fed;
        int         phase;
        int         burst;
        logic [7:0] w;
        logic [7:0] h;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        after_byte = 1'b0;
        for (int i = 0; i < $size(DIRECTED_PLAN); i++) begin
            row = DIRECTED_PLAN[i];
            if (row.kind == PLAN_WRITE) begin
                if (after_byte) begin
                    drain_results();
                end
                set_register(row.index, row.value);
                after_byte = 1'b0;
            end else begin
                push_source_byte(row.value, row.kind == PLAN_BYTE_KNOWN, row.known);
                after_byte = 1'b1;
            end
        end

        // Random phases; the row counter must not reach the row total before the end,
        // since a finished image stays finished until reset.
        fed   = 0;
        phase = 0;
        while (fed < RANDOM_ITEMS && int'(row_cnt) < ROW_CAP) begin
            drain_results();
            if (int'(row_cnt) < 180 && $urandom_range(0, 3) == 0) begin
                w = 8'd0;
            end else if (int'(row_cnt) < 200) begin
                w = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(25, 255))
                                                : 8'($urandom_range(1, 24));
            end else begin
                w = 8'($urandom_range(100, 255));
            end
            // Now and then a height at or below the current row, so bytes are ignored.
            h = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, row_cnt)) : 8'd255;
            set_register(REG_IMAGE_WIDTH, w);
            set_register(REG_IMAGE_HEIGHT, h);
            set_register(REG_CROP_COL_MIN, crop_bound(8'd0));
            set_register(REG_CROP_ROW_MIN, crop_bound(8'd0));
            set_register(REG_CROP_COL_MAX, crop_bound(8'd255));
            set_register(REG_CROP_ROW_MAX, crop_bound(8'd255));
            case ($urandom_range(0, 2))
                0: tx_gap_pct = 0;
                1: tx_gap_pct = 10;
                default: tx_gap_pct = 40;
            endcase
            if (phase == 2) begin
                hold_req = 1'b1;
            end
            burst = $urandom_range(20, 90);
            for (int n = 0; n < burst && int'(row_cnt) < ROW_CAP; n++) begin
                busy = !image_complete();
                push_source_byte(8'($urandom_range(0, 255)), 1'b0, '0);
                if (busy) begin
                    fed++;
                end
            end
            phase++;
        end

        // Finish the image two rows on, then feed a few bytes past its end.
        drain_results();
        set_register(REG_IMAGE_WIDTH, 8'($urandom_range(1, 12)));
        set_register(REG_IMAGE_HEIGHT, row_cnt + 8'd2);
        while (!done_seen) begin
            push_source_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        end
        for (int n = 0; n < 6; n++) begin
            push_source_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        end
        // In whole-screen mode a finished image reports address 0.
        drain_results();
        set_register(REG_IMAGE_WIDTH, 8'd0);
        for (int n = 0; n < 3; n++) begin
            push_source_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ----- packed_seven_bit_pixel_unpacker.f -----
hw/rtl/psbpu_pkg.sv
hw/rtl/packed_seven_bit_pixel_unpacker.sv
sim/tb_packed_seven_bit_pixel_unpacker.sv
